### rtl/dabt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dabt_pkg - shared types and constants of the daily alarm bell timer
// Command codes, table sizing and the packed words of the command and result
// channels.
// ----------------------------------------------------------------------------
package dabt_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W       = ((CNT_W > 6) ? CNT_W : 6) + 1;

	localparam logic [4:0]  MAX_HOUR     = 5'd23;
	localparam logic [5:0]  MAX_MINUTE   = 6'd59;
	localparam logic [15:0] TPS_RESET    = 16'd1000;
	localparam logic [6:0]  MINUTE_NONE  = 7'd127;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] duration_sec;
		logic [5:0]  index;
		logic        time_valid;
	} in_word_t;

	typedef struct packed {
		logic       bell_on;
		logic       accepted;
		logic [5:0] entry_count;
		logic       rang_now;
	} out_word_t;

	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] seconds;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### rtl/dabt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dabt_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dabt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/daily_alarm_table_bell_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daily_alarm_table_bell_timer - alarm table with bell ring timer
// Tick without scan, add and clear show done in the cycle after acceptance;
//   a minute scan walks the stored entries in order and stops at the first
//   hit, which adds the ring length multiply; remove moves each later entry
//   down by one slot.
// One word at a time: a new word is taken only while the block is idle.
// Reset clears the table count, ring state and last minute; the tick rate
//   register resets to 1000. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module daily_alarm_table_bell_timer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire dabt_pkg::in_word_t   item,
	output      logic                 done,
	output      dabt_pkg::out_word_t  result,
	input  wire logic                 tps_we,
	input  wire logic [15:0]          tps_wdata
);

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_REM  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration and bell state.
	logic [15:0]                 tps_q;
	logic                        ringing_q;
	logic [31:0]                 elapsed_q;
	logic [31:0]                 ring_ticks_q;
	logic [6:0]                  last_min_q;
	logic [dabt_pkg::CNT_W-1:0]  used_q;

	// Per-word working registers.
	logic [4:0]                  hour_q;
	logic [5:0]                  minute_q;
	logic [dabt_pkg::CNT_W-1:0]  k_q;
	logic [dabt_pkg::IDX_W-1:0]  wk_q;
	logic                        pend_q;
	logic [15:0]                 sec_q;
	logic                        acc_q;
	logic                        rang_q;

	// Table RAM.
	logic                          ram_we;
	logic [dabt_pkg::IDX_W-1:0]    ram_waddr;
	dabt_pkg::entry_t              ram_wdata;
	logic [dabt_pkg::IDX_W-1:0]    ram_raddr;
	logic [dabt_pkg::ENTRY_W-1:0]  ram_rdata_raw;
	dabt_pkg::entry_t              rd_entry;

	logic                          accept;
	logic                          add_ok;
	logic                          rem_ok;
	logic                          new_minute;
	logic [dabt_pkg::CNT_W:0]      k_next;
	logic                          more_rem;
	logic                          more_scan;
	logic                          hit;
	logic [31:0]                   elapsed_inc;
	logic                          ring_end;

	dabt_ram #(
		.WIDTH(dabt_pkg::ENTRY_W),
		.DEPTH(dabt_pkg::MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	assign rd_entry = dabt_pkg::entry_t'(ram_rdata_raw);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Add is legal only for a real time of day, a nonzero length and room left.
	assign add_ok = (item.hour <= dabt_pkg::MAX_HOUR) && (item.minute <= dabt_pkg::MAX_MINUTE)
		&& (item.duration_sec != 16'd0)
		&& (used_q < dabt_pkg::CNT_W'(dabt_pkg::MAX_ENTRIES));
	assign rem_ok = dabt_pkg::CMP_W'(item.index) < dabt_pkg::CMP_W'(used_q);
	assign new_minute = item.time_valid && ({1'b0, item.minute} != last_min_q);

	// Ring advance on a tick: saturating count, then end check.
	assign elapsed_inc = (elapsed_q != 32'hFFFF_FFFF) ? elapsed_q + 32'd1 : elapsed_q;
	assign ring_end    = (elapsed_inc >= ring_ticks_q);

	// Walk pointers: scan reads entry k, compaction reads entry k+1.
	assign k_next    = {1'b0, k_q} + (dabt_pkg::CNT_W + 1)'(1);
	assign more_scan = (k_q < used_q);
	assign more_rem  = (k_next < {1'b0, used_q});
	assign hit       = pend_q && (rd_entry.hour == hour_q) && (rd_entry.minute == minute_q);

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = used_q[dabt_pkg::IDX_W-1:0];
		ram_wdata = '{hour: item.hour, minute: item.minute, seconds: item.duration_sec};
		ram_raddr = k_q[dabt_pkg::IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				ram_we = accept && (dabt_pkg::cmd_t'(item.cmd) == dabt_pkg::CMD_ADD) && add_ok;
			end
			ST_REM: begin
				// Move the entry read last cycle down by one slot.
				ram_we    = pend_q;
				ram_waddr = wk_q;
				ram_wdata = rd_entry;
				ram_raddr = k_next[dabt_pkg::IDX_W-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tps_q        <= dabt_pkg::TPS_RESET;
			ringing_q    <= 1'b0;
			elapsed_q    <= '0;
			ring_ticks_q <= '0;
			last_min_q   <= dabt_pkg::MINUTE_NONE;
			used_q       <= '0;
			pend_q       <= 1'b0;
			acc_q        <= 1'b0;
			rang_q       <= 1'b0;
		end else begin
			if (tps_we) begin
				tps_q <= tps_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hour_q   <= item.hour;
						minute_q <= item.minute;
						rang_q   <= 1'b0;
						pend_q   <= 1'b0;
						case (dabt_pkg::cmd_t'(item.cmd))
							dabt_pkg::CMD_TICK: begin
								acc_q <= 1'b1;
								if (ringing_q) begin
									elapsed_q <= elapsed_inc;
									if (ring_end) begin
										ringing_q <= 1'b0;
									end
								end
								if (new_minute) begin
									last_min_q <= {1'b0, item.minute};
									k_q        <= '0;
									state_q    <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							dabt_pkg::CMD_ADD: begin
								acc_q   <= add_ok;
								state_q <= ST_DONE;
								if (add_ok) begin
									used_q <= used_q + dabt_pkg::CNT_W'(1);
								end
							end
							dabt_pkg::CMD_REMOVE: begin
								acc_q <= rem_ok;
								if (rem_ok) begin
									k_q     <= dabt_pkg::CNT_W'(item.index);
									state_q <= ST_REM;
								end else begin
									state_q <= ST_DONE;
								end
							end
							dabt_pkg::CMD_CLEAR: begin
								acc_q   <= 1'b1;
								used_q  <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								acc_q   <= 1'b1;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Compare the entry read last cycle while the next read goes out.
					if (hit) begin
						sec_q   <= rd_entry.seconds;
						pend_q  <= 1'b0;
						state_q <= ST_MUL;
					end else if (more_scan) begin
						k_q    <= k_next[dabt_pkg::CNT_W-1:0];
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					// Restart the ring with the matched length.
					ring_ticks_q <= 32'(sec_q) * 32'(tps_q);
					elapsed_q    <= '0;
					ringing_q    <= 1'b1;
					rang_q       <= 1'b1;
					state_q      <= ST_DONE;
				end
				ST_REM: begin
					if (more_rem) begin
						wk_q   <= k_q[dabt_pkg::IDX_W-1:0];
						k_q    <= k_next[dabt_pkg::CNT_W-1:0];
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							used_q  <= used_q - dabt_pkg::CNT_W'(1);
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result word shows for the single DONE cycle.
	assign done                = (state_q == ST_DONE);
	assign result.bell_on      = ringing_q;
	assign result.accepted     = acc_q;
	assign result.entry_count  = 6'(used_q);
	assign result.rang_now     = rang_q;

	// An accepted word always makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("block not busy after accepting a word");

	// The result strobe lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A started ring always shows the bell on and the word accepted.
	a_rang_bell: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.rang_now) |-> (result.bell_on && result.accepted))
		else $error("ring start without bell on");

	// The table never holds more than its capacity.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= dabt_pkg::CNT_W'(dabt_pkg::MAX_ENTRIES))
		else $error("entry count above table size");

endmodule
`default_nettype wire

### test/daily_alarm_table_bell_timer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// daily_alarm_table_bell_timer_tb - self-checking bench for the alarm table
// A directed table covers the add and remove error cases, ring start,
// retrigger, minute rescan rules and table edits while ringing. Random words
// follow across several tick rates, including 0 and 65535. A behavioral copy
// of the table and ring predicts each result word that a directed row does
// not spell out, and a monitor compares each field in order.
// ----------------------------------------------------------------------------
module daily_alarm_table_bell_timer_tb;
	import dabt_pkg::*;

	localparam int RANDOM_BATCH = 150;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} probe_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    item;
	logic        done;
	out_word_t   result;
	logic        tps_we;
	logic [15:0] tps_wdata;

	// Behavioral copy of the block: alarm table, ring timer and tick rate.
	entry_t      table_now [MAX_ENTRIES];
	int          table_fill;
	logic        bell_live;
	logic [31:0] ring_elapsed;
	logic [31:0] ring_length;
	logic [6:0]  minute_last;
	logic [15:0] rate_now;

	out_word_t   status_due [$];
	probe_row_t  probe_rows [$];
	logic [15:0] rate_plan [6];
	int          faults;
	int          sent;
	int          fill_left;
	int          cycles;

	daily_alarm_table_bell_timer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.tps_we    (tps_we),
		.tps_wdata (tps_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the behavioral table by one command word and return the status
	// word the block should report for it.
	function automatic out_word_t next_bell_status(input in_word_t w);
		out_word_t r;
		logic      ok;
		logic      fired;
		ok    = 1'b1;
		fired = 1'b0;
		case (w.cmd)
			CMD_TICK: begin
				// A running ring advances first and ends once its length is reached.
				if (bell_live) begin
					if (ring_elapsed != 32'hFFFF_FFFF)
						ring_elapsed++;
					if (ring_elapsed >= ring_length)
						bell_live = 1'b0;
				end
				// Scan once per new valid minute; the first match wins.
				if (w.time_valid && {1'b0, w.minute} != minute_last) begin
					minute_last = {1'b0, w.minute};
					for (int k = 0; k < table_fill; k++) begin
						if (!fired && table_now[k].hour == w.hour
								&& table_now[k].minute == w.minute) begin
							fired        = 1'b1;
							bell_live    = 1'b1;
							ring_elapsed = '0;
							ring_length  = {16'd0, table_now[k].seconds} * {16'd0, rate_now};
						end
					end
				end
			end
			CMD_ADD: begin
				if (w.hour > MAX_HOUR || w.minute > MAX_MINUTE || w.duration_sec == '0
						|| table_fill >= MAX_ENTRIES)
					ok = 1'b0;
				else begin
					table_now[table_fill] = '{w.hour, w.minute, w.duration_sec};
					table_fill++;
				end
			end
			CMD_REMOVE: begin
				if (w.index >= table_fill)
					ok = 1'b0;
				else begin
					// Compact: later entries move down by one.
					for (int k = w.index; k + 1 < table_fill; k++)
						table_now[k] = table_now[k + 1];
					table_fill--;
				end
			end
			default: begin
				table_fill = 0;
			end
		endcase
		r.bell_on     = bell_live;
		r.accepted    = ok;
		r.entry_count = 6'(table_fill);
		r.rang_now    = fired;
		return r;
	endfunction

	function automatic out_word_t status(input bit b, input bit a, input int n, input bit r);
		out_word_t s;
		s = '{b, a, 6'(n), r};
		return s;
	endfunction

	function automatic void add_row(input cmd_t c, input logic [4:0] h, input logic [5:0] m,
			input logic [15:0] d, input logic [5:0] idx, input logic v, input bit typed,
			input out_word_t want);
		probe_row_t p;
		p.w     = '{c, h, m, d, idx, v};
		p.typed = typed;
		p.want  = want;
		probe_rows = {probe_rows, p};
	endfunction

	// Draw one random command word. Mostly well-formed traffic that reaches the
	// ring logic: ticks aimed at stored alarms, valid adds with short rings,
	// in-range removes, and now and then a burst of adds that overfills the table.
	function automatic in_word_t draw_word();
		in_word_t    w;
		logic [63:0] noise;
		int          pick;
		int          sel;
		int          k;
		bit          filling;
		noise   = {$urandom, $urandom};
		w       = noise[$bits(in_word_t)-1:0];
		filling = (fill_left > 0);
		if (filling) begin
			fill_left--;
			pick = 60;
		end else begin
			if ($urandom_range(0, 199) < 3)
				fill_left = MAX_ENTRIES + 2;
			pick = $urandom_range(0, 99);
		end
		if (pick < 50) begin
			w.cmd        = CMD_TICK;
			w.time_valid = ($urandom_range(0, 9) != 0);
			sel          = $urandom_range(0, 9);
			if (table_fill > 0 && sel < 4) begin
				k        = $urandom_range(0, table_fill - 1);
				w.hour   = table_now[k].hour;
				w.minute = table_now[k].minute;
			end else if (sel < 5)
				w.minute = minute_last[5:0];
			else if (sel < 9)
				w.hour = 5'($urandom_range(0, 23));
			// otherwise hour and minute keep their full random range
		end else if (pick < 75) begin
			w.cmd = CMD_ADD;
			if (!filling && $urandom_range(0, 6) == 0) begin
				// Force one rule to break; the other fields stay random.
				case ($urandom_range(0, 2))
					0:       w.hour = 5'($urandom_range(24, 31));
					1:       w.minute = 6'($urandom_range(60, 63));
					default: w.duration_sec = '0;
				endcase
			end else begin
				w.hour   = 5'($urandom_range(0, 23));
				w.minute = 6'($urandom_range(0, 59));
				// Duplicate a stored time now and then so that order decides the hit.
				if (table_fill > 0 && $urandom_range(0, 4) == 0) begin
					k        = $urandom_range(0, table_fill - 1);
					w.hour   = table_now[k].hour;
					w.minute = table_now[k].minute;
				end
				sel = $urandom_range(0, 9);
				if (sel < 7)
					w.duration_sec = 16'($urandom_range(1, 3));
				else if (sel < 9)
					w.duration_sec = 16'($urandom_range(1, 65535));
				else
					w.duration_sec = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
			end
		end else if (pick < 95) begin
			w.cmd = CMD_REMOVE;
			if (table_fill > 0 && $urandom_range(0, 4) != 0)
				w.index = 6'($urandom_range(0, table_fill - 1));
		end else
			w.cmd = CMD_CLEAR;
		return w;
	endfunction

	// Present one word, hold it until the block takes it, log the expected
	// status, then idle the sender for a random gap. Stretches of 48 words run
	// back to back with start held high.
	task automatic issue_word(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t predicted;
		int        gap;
		int        sel;
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		predicted = next_bell_status(w);
		status_due = {status_due, (typed ? want : predicted)};
		sent++;
		gap = 0;
		if (((sent / 48) % 4) != 1) begin
			sel = $urandom_range(0, 99);
			if (sel >= 90)
				gap = $urandom_range(5, 40);
			else if (sel >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and wait until every expected word has come back.
	task automatic settle();
		start <= 1'b0;
		while (status_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic set_tick_rate(input logic [15:0] v);
		tps_we    <= 1'b1;
		tps_wdata <= v;
		@(posedge clk);
		tps_we    <= 1'b0;
		rate_now  = v;
	endtask

	// Compare each result word, field by field, with the oldest expectation.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (status_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("unexpected result word: bell %0b accepted %0b count %0d rang %0b",
						result.bell_on, result.accepted, result.entry_count, result.rang_now);
			end else begin
				want = status_due.pop_front();
				if (result.bell_on !== want.bell_on || result.accepted !== want.accepted
						|| result.entry_count !== want.entry_count
						|| result.rang_now !== want.rang_now) begin
					faults++;
					if (faults <= REPORT_LIMIT)
						$display("mismatch (exp/act): bell %0b/%0b accepted %0b/%0b count %0d/%0d rang %0b/%0b",
							want.bell_on, result.bell_on, want.accepted, result.accepted,
							want.entry_count, result.entry_count, want.rang_now, result.rang_now);
				end
			end
		end
	end

	// Bound the run in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		tps_we       = 1'b0;
		tps_wdata    = '0;
		cycles       = 0;
		faults       = 0;
		sent         = 0;
		fill_left    = 0;
		table_fill   = 0;
		bell_live    = 1'b0;
		ring_elapsed = '0;
		ring_length  = '0;
		minute_last  = MINUTE_NONE;
		rate_now     = TPS_RESET;
		foreach (table_now[k])
			table_now[k] = '0;

		// Directed rows run at the reset tick rate, so any ring started here
		// lasts far longer than the table itself.
		add_row(CMD_TICK,   5'd0,  6'd0,  16'd0,     6'd0,  1'b0, 1'b1, status(0, 1, 0, 0));
		add_row(CMD_REMOVE, 5'd0,  6'd0,  16'd0,     6'd0,  1'b0, 1'b1, status(0, 0, 0, 0));
		add_row(CMD_ADD,    5'd24, 6'd0,  16'd1,     6'd0,  1'b0, 1'b1, status(0, 0, 0, 0));
		add_row(CMD_ADD,    5'd31, 6'd63, 16'hFFFF,  6'd63, 1'b1, 1'b1, status(0, 0, 0, 0));
		add_row(CMD_ADD,    5'd0,  6'd60, 16'd1,     6'd0,  1'b0, 1'b1, status(0, 0, 0, 0));
		add_row(CMD_ADD,    5'd0,  6'd0,  16'd0,     6'd0,  1'b0, 1'b1, status(0, 0, 0, 0));
		add_row(CMD_ADD,    5'd23, 6'd59, 16'hFFFF,  6'd0,  1'b0, 1'b1, status(0, 1, 1, 0));
		add_row(CMD_ADD,    5'd0,  6'd0,  16'd1,     6'd0,  1'b0, 1'b1, status(0, 1, 2, 0));
		add_row(CMD_ADD,    5'd12, 6'd30, 16'd2,     6'd0,  1'b0, 1'b1, status(0, 1, 3, 0));
		add_row(CMD_ADD,    5'd0,  6'd0,  16'd3,     6'd0,  1'b0, 1'b1, status(0, 1, 4, 0));
		// First match at 00:00 starts the ring; the same minute does not rescan.
		add_row(CMD_TICK,   5'd0,  6'd0,  16'd0,     6'd0,  1'b1, 1'b1, status(1, 1, 4, 1));
		add_row(CMD_TICK,   5'd0,  6'd0,  16'd0,     6'd0,  1'b1, 1'b0, '0);
		// Retrigger from the longest entry, then an invalid clock and a bad hour.
		add_row(CMD_TICK,   5'd23, 6'd59, 16'd0,     6'd0,  1'b1, 1'b0, '0);
		add_row(CMD_TICK,   5'd0,  6'd0,  16'd0,     6'd0,  1'b0, 1'b0, '0);
		add_row(CMD_TICK,   5'd31, 6'd1,  16'd0,     6'd0,  1'b1, 1'b0, '0);
		// Table edits leave the ring running.
		add_row(CMD_REMOVE, 5'd0,  6'd0,  16'd0,     6'd63, 1'b0, 1'b1, status(1, 0, 4, 0));
		add_row(CMD_REMOVE, 5'd0,  6'd0,  16'd0,     6'd0,  1'b0, 1'b0, '0);
		add_row(CMD_TICK,   5'd12, 6'd30, 16'd0,     6'd0,  1'b1, 1'b0, '0);
		add_row(CMD_CLEAR,  5'd0,  6'd0,  16'd0,     6'd0,  1'b0, 1'b1, status(1, 1, 0, 0));
		add_row(CMD_REMOVE, 5'd0,  6'd0,  16'd0,     6'd0,  1'b0, 1'b1, status(1, 0, 0, 0));
		add_row(CMD_TICK,   5'd0,  6'd0,  16'd0,     6'd0,  1'b1, 1'b0, '0);

		rate_plan = '{16'd1, 16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(2, 5)), TPS_RESET};

		// Hold reset, then release it on a rising edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i])
			issue_word(probe_rows[i].w, probe_rows[i].typed, probe_rows[i].want);

		// First random batch keeps the reset tick rate; each later one follows
		// a rate change made while the block is idle.
		repeat (RANDOM_BATCH) issue_word(draw_word(), 1'b0, '0);
		foreach (rate_plan[p]) begin
			settle();
			set_tick_rate(rate_plan[p]);
			repeat (RANDOM_BATCH) issue_word(draw_word(), 1'b0, '0);
		end

		settle();
		// Give any stray result word time to show up.
		repeat (40) @(posedge clk);
		faults += status_due.size();
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
rtl/dabt_pkg.sv
rtl/dabt_ram.sv
rtl/daily_alarm_table_bell_timer.sv
test/daily_alarm_table_bell_timer_tb.sv
